// ===== rtl/sweep_prune_endpoint_axis_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SWEEP_PRUNE_ENDPOINT_AXIS_TOP_DEFINES_SVH
`define SWEEP_PRUNE_ENDPOINT_AXIS_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SPE_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked on every clock edge, reset included.
`define SPE_CHECK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/spe_pkg.sv =====
`timescale 1ns / 1ps
package spe_pkg;

  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_SET    = 3'd2;
  localparam logic [2:0] MODE_SORT   = 3'd3;
  localparam logic [2:0] MODE_COUNT  = 3'd4;
  localparam logic [2:0] MODE_READ   = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic [9:0]         first_id;
    logic [9:0]         second_id;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic [7:0]         read_index;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        test_count;
    logic [9:0]         entry_id;
    logic               entry_is_max;
    logic signed [31:0] entry_value;
    logic [8:0]         endpoint_count;
  } out_t;

  typedef struct packed {
    logic [9:0]         id;
    logic               is_max;
    logic signed [31:0] value;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH, S_ADD_LO, S_ADD_HI, S_RM_RD, S_RM_CK, S_SH_RD, S_SH_WR,
    S_SV_RD, S_SV_CK, S_SV_WR, S_RD_RD, S_RD_CAP, S_CT_RD, S_CT_CK,
    S_IS_RDI, S_IS_RDP, S_IS_CKP, S_IS_WR, S_IS_CK2, S_IS_PUT,
    S_QS_INIT0, S_QS_INIT1, S_QS_POP, S_QS_POP2, S_QS_DEC,
    S_QP_RR, S_QP_SW, S_QP_SW2, S_QP_IR, S_QP_IC, S_QP_JR, S_QP_JC, S_QP_SWJ,
    S_QP_END, S_QP_END2, S_QP_PUSH, S_DONE
  } spe_state_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_DISPATCH, OP_ADD_LO, OP_ADD_HI, OP_RM_RD, OP_RM_CK,
    OP_SH_RD, OP_SH_WR, OP_SV_RD, OP_SV_CK, OP_SV_WR, OP_RD_RD, OP_RD_CAP,
    OP_CT_RD, OP_CT_CK, OP_IS_RDI, OP_IS_RDP, OP_IS_CKP, OP_IS_WR, OP_IS_PUT,
    OP_QS_INIT0, OP_QS_INIT1, OP_QS_POP, OP_QS_POP2, OP_QS_DEC,
    OP_QP_RR, OP_QP_SW, OP_QP_SW2, OP_QP_IR, OP_QP_IC, OP_QP_JR, OP_QP_JC,
    OP_QP_SWJ, OP_QP_END, OP_QP_END2, OP_QP_PUSH, OP_EMIT
  } spe_op_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       full;
    logic       ridx_ok;
    logic       i_lt_cnt;
    logic       rd_match;
    logic       found;
    logic       i_eq_p1;
    logic       sv_match;
    logic       i_gt_hi;
    logic       gt_t;
    logic       j_gt1;
    logic       over;
    logic       ir;
    logic       sp_zero;
    logic       part_ok;
    logic       lt_piv;
    logic       j_cont;
    logic       i_ge_j;
    logic       push_last;
  } spe_flags_t;

endpackage

// ===== rtl/sweep_prune_endpoint_axis_top.sv =====
`timescale 1ns / 1ps
// Channel   Ports                          Payload
// request   in_valid / in_ready / in_data  spe_pkg::in_t (mode, ids, values, index)
// result    out_valid / out_ready / out_data spe_pkg::out_t (status, counts, entry)
//
// One request is worked at a time; the endpoint store has one write port and
// one read port with a registered read, so each visited entry is read, then
// acted on.
// Reset (rst_n low, synchronous) empties the store; no clearing pass is needed.
// A waiting result sits in the output register while the next request is taken.
module sweep_prune_endpoint_axis_top #(
  parameter int CAPACITY    = 256,
  parameter int SMALL_RANGE = 16,
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  spe_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output spe_pkg::out_t  out_data
);
  import spe_pkg::*;

  // The controller sequences every mode as a chain of datapath operations.
  // It sees only the status flags; the datapath owns the store, the range
  // stack and all indices.
  spe_flags_t flags;
  spe_op_t    op;

  spe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flags     (flags),
    .op        (op)
  );

  // The sort runs insertion first and falls back to a stack quicksort once the
  // move count passes the log-scaled limit; the quicksort does not keep the
  // original ordering of equal values.
  spe_datapath #(
    .CAPACITY    (CAPACITY),
    .SMALL_RANGE (SMALL_RANGE),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .op       (op),
    .flags    (flags),
    .out_data (out_data)
  );

endmodule

// ===== rtl/spe_ctrl.sv =====
`timescale 1ns / 1ps
module spe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  spe_pkg::spe_flags_t flags,
  output spe_pkg::spe_op_t   op
);
  import spe_pkg::*;

  spe_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        case (flags.mode)
          MODE_ADD:    state_nxt = flags.full ? S_DONE : S_ADD_LO;
          MODE_REMOVE: state_nxt = S_RM_RD;
          MODE_SET:    state_nxt = S_SV_RD;
          MODE_SORT:   state_nxt = S_IS_RDI;
          MODE_COUNT:  state_nxt = S_CT_RD;
          MODE_READ:   state_nxt = flags.ridx_ok ? S_RD_RD : S_DONE;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_ADD_LO:   state_nxt = S_ADD_HI;
      S_ADD_HI:   state_nxt = S_DONE;
      S_RM_RD:    state_nxt = flags.i_lt_cnt ? S_RM_CK : S_DONE;
      S_RM_CK:    state_nxt = (flags.rd_match && flags.found) ? S_SH_RD : S_RM_RD;
      S_SH_RD: begin
        if (!flags.i_lt_cnt) state_nxt = S_DONE;
        else if (flags.i_eq_p1) state_nxt = S_SH_RD;
        else state_nxt = S_SH_WR;
      end
      S_SH_WR:    state_nxt = S_SH_RD;
      S_SV_RD:    state_nxt = flags.i_lt_cnt ? S_SV_CK : S_DONE;
      S_SV_CK:    state_nxt = flags.sv_match ? S_SV_WR : S_SV_RD;
      S_SV_WR:    state_nxt = S_DONE;
      S_RD_RD:    state_nxt = S_RD_CAP;
      S_RD_CAP:   state_nxt = S_DONE;
      S_CT_RD:    state_nxt = flags.i_lt_cnt ? S_CT_CK : S_DONE;
      S_CT_CK:    state_nxt = S_CT_RD;
      S_IS_RDI: begin
        if (!flags.i_gt_hi) state_nxt = S_IS_RDP;
        else state_nxt = flags.ir ? S_QS_POP : S_DONE;
      end
      S_IS_RDP:   state_nxt = S_IS_CKP;
      S_IS_CKP:   state_nxt = flags.gt_t ? S_IS_WR : S_IS_RDI;
      S_IS_WR:    state_nxt = flags.j_gt1 ? S_IS_CK2 : S_IS_PUT;
      S_IS_CK2:   state_nxt = flags.gt_t ? S_IS_WR : S_IS_PUT;
      S_IS_PUT:   state_nxt = (!flags.ir && flags.over) ? S_QS_INIT0 : S_IS_RDI;
      S_QS_INIT0: state_nxt = S_QS_INIT1;
      S_QS_INIT1: state_nxt = S_QS_POP;
      S_QS_POP:   state_nxt = flags.sp_zero ? S_DONE : S_QS_POP2;
      S_QS_POP2:  state_nxt = S_QS_DEC;
      S_QS_DEC:   state_nxt = flags.part_ok ? S_QP_RR : S_IS_RDI;
      S_QP_RR:    state_nxt = S_QP_SW;
      S_QP_SW:    state_nxt = S_QP_SW2;
      S_QP_SW2:   state_nxt = S_QP_IR;
      S_QP_IR:    state_nxt = S_QP_IC;
      S_QP_IC:    state_nxt = flags.lt_piv ? S_QP_IR : S_QP_JR;
      S_QP_JR:    state_nxt = S_QP_JC;
      S_QP_JC: begin
        if (flags.j_cont) state_nxt = S_QP_JR;
        else state_nxt = flags.i_ge_j ? S_QP_END : S_QP_SWJ;
      end
      S_QP_SWJ:   state_nxt = S_QP_IR;
      S_QP_END:   state_nxt = S_QP_END2;
      S_QP_END2:  state_nxt = S_QP_PUSH;
      S_QP_PUSH:  state_nxt = flags.push_last ? S_QS_POP : S_QP_PUSH;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NOP;
    case (state_r)
      S_IDLE:     op = in_valid ? OP_LOAD : OP_NOP;
      S_DISPATCH: op = OP_DISPATCH;
      S_ADD_LO:   op = OP_ADD_LO;
      S_ADD_HI:   op = OP_ADD_HI;
      S_RM_RD:    op = OP_RM_RD;
      S_RM_CK:    op = OP_RM_CK;
      S_SH_RD:    op = OP_SH_RD;
      S_SH_WR:    op = OP_SH_WR;
      S_SV_RD:    op = OP_SV_RD;
      S_SV_CK:    op = OP_SV_CK;
      S_SV_WR:    op = OP_SV_WR;
      S_RD_RD:    op = OP_RD_RD;
      S_RD_CAP:   op = OP_RD_CAP;
      S_CT_RD:    op = OP_CT_RD;
      S_CT_CK:    op = OP_CT_CK;
      S_IS_RDI:   op = OP_IS_RDI;
      S_IS_RDP:   op = OP_IS_RDP;
      S_IS_CKP:   op = OP_IS_CKP;
      S_IS_WR:    op = OP_IS_WR;
      S_IS_CK2:   op = OP_NOP;
      S_IS_PUT:   op = OP_IS_PUT;
      S_QS_INIT0: op = OP_QS_INIT0;
      S_QS_INIT1: op = OP_QS_INIT1;
      S_QS_POP:   op = OP_QS_POP;
      S_QS_POP2:  op = OP_QS_POP2;
      S_QS_DEC:   op = OP_QS_DEC;
      S_QP_RR:    op = OP_QP_RR;
      S_QP_SW:    op = OP_QP_SW;
      S_QP_SW2:   op = OP_QP_SW2;
      S_QP_IR:    op = OP_QP_IR;
      S_QP_IC:    op = OP_QP_IC;
      S_QP_JR:    op = OP_QP_JR;
      S_QP_JC:    op = OP_QP_JC;
      S_QP_SWJ:   op = OP_QP_SWJ;
      S_QP_END:   op = OP_QP_END;
      S_QP_END2:  op = OP_QP_END2;
      S_QP_PUSH:  op = OP_QP_PUSH;
      S_DONE:     op = out_free ? OP_EMIT : OP_NOP;
      default:    op = OP_NOP;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == S_DONE && out_free) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/spe_datapath.sv =====
`timescale 1ns / 1ps
module spe_datapath #(
  parameter int CAPACITY    = 256,
  parameter int SMALL_RANGE = 16,
  parameter int STACK_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  spe_pkg::in_t        in_data,
  input  spe_pkg::spe_op_t    op,
  output spe_pkg::spe_flags_t flags,
  output spe_pkg::out_t       out_data
);
  import spe_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = AW + 2;
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int MW  = 2 * AW + 2;
  localparam int LW  = $clog2(CW + 1);
  localparam int SW  = 2 * AW + 3;

  entry_t mem [CAPACITY];
  logic signed [IW-1:0] stk [STACK_DEPTH];

  in_t                  req_r, req_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [IW-1:0] i_r, i_nxt, j_r, j_nxt, left_r, left_nxt, right_r, right_nxt;
  logic signed [IW-1:0] p1_r, p1_nxt, srdata_r;
  logic                 found_r, found_nxt, ir_r, ir_nxt, bigleft_r, bigleft_nxt;
  logic [MW-1:0]        moves_r, moves_nxt, limit_r, limit_nxt;
  entry_t               t_r, t_nxt, piv_r, piv_nxt, a_r, a_nxt, rdata_r;
  entry_t               rentry_r, rentry_nxt;
  logic [SPW-1:0]       sp_r, sp_nxt;
  logic [1:0]           pushk_r, pushk_nxt, status_r, status_nxt;
  logic signed [AW+1:0] open_r, open_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [15:0]          test_r, test_nxt;
  out_t                 out_r, out_nxt;

  logic                 mem_we, mem_re, stk_we, stk_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  entry_t               mem_wdata;
  logic [SAW-1:0]       stk_waddr, stk_raddr;
  logic signed [IW-1:0] stk_wdata;

  logic signed [IW-1:0] cnt_s, mid;
  logic signed [IW:0]   diff_q;
  logic [LW-1:0]        lg;
  logic [LW+CW-1:0]     lg_cnt;
  logic [MW-1:0]        moves_sum;

  assign cnt_s     = $signed(IW'(cnt_r));
  assign diff_q    = (IW+1)'(right_r) - (IW+1)'(srdata_r);
  assign mid       = srdata_r + IW'(diff_q >>> 1);
  assign moves_sum = moves_r + MW'(i_r - j_r);
  assign lg_cnt    = (LW+CW)'(lg) * (LW+CW)'(cnt_r);

  // Bit length of the count, at least one.
  always_comb begin
    lg = LW'(1);
    for (int k = 0; k < CW; k++) begin
      if (cnt_r[k]) lg = LW'(k + 1);
    end
  end

  always_comb begin
    flags.mode      = req_r.mode;
    flags.full      = (32'(cnt_r) + 2) > CAPACITY;
    flags.ridx_ok   = 32'(req_r.read_index) < 32'(cnt_r);
    flags.i_lt_cnt  = i_r < cnt_s;
    flags.rd_match  = (rdata_r.id == req_r.first_id) || (rdata_r.id == req_r.second_id);
    flags.found     = found_r;
    flags.i_eq_p1   = i_r == p1_r;
    flags.sv_match  = rdata_r.id == req_r.first_id;
    flags.i_gt_hi   = i_r > right_r;
    flags.gt_t      = $signed(rdata_r.value) > $signed(t_r.value);
    flags.j_gt1     = j_r > IW'(1);
    flags.over      = moves_sum > limit_r;
    flags.ir        = ir_r;
    flags.sp_zero   = sp_r == '0;
    flags.part_ok   = (int'(diff_q) > SMALL_RANGE) && (32'(sp_r) + 4 <= STACK_DEPTH);
    flags.lt_piv    = $signed(rdata_r.value) < $signed(piv_r.value);
    flags.j_cont    = ($signed(piv_r.value) < $signed(rdata_r.value)) && (j_r != left_r);
    flags.i_ge_j    = i_r >= j_r;
    flags.push_last = pushk_r == 2'd3;
  end

  always_comb begin
    req_nxt = req_r;     cnt_nxt = cnt_r;       i_nxt = i_r;         j_nxt = j_r;
    left_nxt = left_r;   right_nxt = right_r;   p1_nxt = p1_r;       found_nxt = found_r;
    ir_nxt = ir_r;       bigleft_nxt = bigleft_r; moves_nxt = moves_r; limit_nxt = limit_r;
    t_nxt = t_r;         piv_nxt = piv_r;       a_nxt = a_r;         rentry_nxt = rentry_r;
    sp_nxt = sp_r;       pushk_nxt = pushk_r;   status_nxt = status_r;
    open_nxt = open_r;   sum_nxt = sum_r;       test_nxt = test_r;   out_nxt = out_r;
    mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = '0;  mem_re = 1'b0;  mem_raddr = '0;
    stk_we = 1'b0;  stk_waddr = '0;  stk_wdata = '0;  stk_re = 1'b0;  stk_raddr = '0;
    case (op)
      OP_LOAD: begin
        req_nxt    = in_data;
        status_nxt = ST_OK;
        test_nxt   = '0;
        rentry_nxt = '0;
      end
      OP_DISPATCH: begin
        case (req_r.mode)
          MODE_ADD:    if (flags.full) status_nxt = ST_FULL;
          MODE_REMOVE: begin
            i_nxt     = '0;
            found_nxt = 1'b0;
          end
          MODE_SET: begin
            i_nxt      = '0;
            status_nxt = ST_MISS;
          end
          MODE_SORT: begin
            limit_nxt = MW'(lg_cnt >> 2);
            moves_nxt = '0;
            i_nxt     = IW'(1);
            right_nxt = cnt_s - IW'(1);
            ir_nxt    = 1'b0;
            sp_nxt    = '0;
          end
          MODE_COUNT: begin
            i_nxt    = IW'(1);
            open_nxt = (AW+2)'(1);
            sum_nxt  = '0;
          end
          MODE_READ:   if (!flags.ridx_ok) status_nxt = ST_MISS;
          default: ;
        endcase
      end
      OP_ADD_LO: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_r);
        mem_wdata = '{id: req_r.first_id, is_max: 1'b0, value: req_r.first_value};
      end
      OP_ADD_HI: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_r + CW'(1));
        mem_wdata = '{id: req_r.second_id, is_max: 1'b1, value: req_r.second_value};
        cnt_nxt   = cnt_r + CW'(2);
      end
      OP_RM_RD: begin
        if (flags.i_lt_cnt) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(i_r);
        end else begin
          status_nxt = ST_MISS;
        end
      end
      OP_RM_CK: begin
        if (flags.rd_match && found_r) begin
          p1_nxt = i_r;
          i_nxt  = left_r + IW'(1);
        end else begin
          if (flags.rd_match) begin
            found_nxt = 1'b1;
            left_nxt  = i_r;
          end
          i_nxt = i_r + IW'(1);
        end
      end
      OP_SH_RD: begin
        if (!flags.i_lt_cnt) begin
          cnt_nxt = cnt_r - CW'(2);
        end else if (flags.i_eq_p1) begin
          i_nxt = i_r + IW'(1);
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(i_r);
        end
      end
      OP_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = (i_r < p1_r) ? AW'(i_r - IW'(1)) : AW'(i_r - IW'(2));
        mem_wdata = rdata_r;
        i_nxt     = i_r + IW'(1);
      end
      OP_SV_RD: begin
        if (flags.i_lt_cnt) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(i_r);
        end
      end
      OP_SV_CK: if (!flags.sv_match) i_nxt = i_r + IW'(1);
      OP_SV_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = AW'(i_r);
        mem_wdata       = rdata_r;
        mem_wdata.value = req_r.first_value;
        status_nxt      = ST_OK;
      end
      OP_RD_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(req_r.read_index);
      end
      OP_RD_CAP: rentry_nxt = rdata_r;
      OP_CT_RD: begin
        if (flags.i_lt_cnt) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(i_r);
        end else if (sum_r < 0) begin
          test_nxt = '0;
        end else if (int'(sum_r) > 65535) begin
          test_nxt = 16'hFFFF;
        end else begin
          test_nxt = 16'(sum_r);
        end
      end
      OP_CT_CK: begin
        if (rdata_r.is_max) begin
          open_nxt = open_r - (AW+2)'(1);
        end else begin
          sum_nxt  = sum_r + SW'(open_r);
          open_nxt = open_r + (AW+2)'(1);
        end
        i_nxt = i_r + IW'(1);
      end
      OP_IS_RDI: begin
        if (!flags.i_gt_hi) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(i_r);
        end
      end
      OP_IS_RDP: begin
        t_nxt     = rdata_r;
        mem_re    = 1'b1;
        mem_raddr = AW'(i_r - IW'(1));
      end
      OP_IS_CKP: begin
        if (flags.gt_t) j_nxt = i_r;
        else i_nxt = i_r + IW'(1);
      end
      OP_IS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(j_r);
        mem_wdata = rdata_r;
        if (flags.j_gt1) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(j_r - IW'(2));
        end
        j_nxt = j_r - IW'(1);
      end
      OP_IS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(j_r);
        mem_wdata = t_r;
        i_nxt     = i_r + IW'(1);
        if (!ir_r) moves_nxt = moves_sum;
      end
      OP_QS_INIT0, OP_QS_INIT1: begin
        stk_we    = 1'b1;
        stk_waddr = SAW'(sp_r);
        stk_wdata = (op == OP_QS_INIT0) ? '0 : cnt_s - IW'(1);
        sp_nxt    = sp_r + SPW'(1);
      end
      OP_QS_POP: begin
        if (!flags.sp_zero) begin
          stk_re    = 1'b1;
          stk_raddr = SAW'(sp_r - SPW'(1));
        end
      end
      OP_QS_POP2: begin
        right_nxt = srdata_r;
        stk_re    = 1'b1;
        stk_raddr = SAW'(sp_r - SPW'(2));
        sp_nxt    = sp_r - SPW'(2);
      end
      OP_QS_DEC: begin
        left_nxt = srdata_r;
        if (flags.part_ok) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(mid);
          j_nxt     = mid;
        end else begin
          i_nxt  = srdata_r + IW'(1);
          ir_nxt = 1'b1;
        end
      end
      OP_QP_RR: begin
        piv_nxt   = rdata_r;
        mem_re    = 1'b1;
        mem_raddr = AW'(right_r);
      end
      OP_QP_SW: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(j_r);
        mem_wdata = rdata_r;
      end
      OP_QP_SW2: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(right_r);
        mem_wdata = piv_r;
        i_nxt     = left_r;
        j_nxt     = right_r;
      end
      OP_QP_IR: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(i_r);
      end
      OP_QP_IC: begin
        if (flags.lt_piv) i_nxt = i_r + IW'(1);
        else a_nxt = rdata_r;
      end
      OP_QP_JR: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(j_r - IW'(1));
        j_nxt     = j_r - IW'(1);
      end
      OP_QP_JC: begin
        if (!flags.j_cont && !flags.i_ge_j) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(i_r);
          mem_wdata = rdata_r;
        end
      end
      OP_QP_SWJ: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(j_r);
        mem_wdata = a_r;
        i_nxt     = i_r + IW'(1);
      end
      OP_QP_END: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(right_r);
        mem_wdata = a_r;
      end
      OP_QP_END2: begin
        mem_we      = 1'b1;
        mem_waddr   = AW'(i_r);
        mem_wdata   = piv_r;
        bigleft_nxt = (i_r - left_r) > (right_r - i_r);
        pushk_nxt   = '0;
      end
      OP_QP_PUSH: begin
        stk_we    = 1'b1;
        stk_waddr = SAW'(sp_r);
        sp_nxt    = sp_r + SPW'(1);
        pushk_nxt = pushk_r + 2'd1;
        // Larger side goes in first so that the smaller one is popped next.
        case ({bigleft_r, pushk_r})
          3'b100:  stk_wdata = left_r;
          3'b101:  stk_wdata = i_r - IW'(1);
          3'b110:  stk_wdata = i_r + IW'(1);
          3'b111:  stk_wdata = right_r;
          3'b000:  stk_wdata = i_r + IW'(1);
          3'b001:  stk_wdata = right_r;
          3'b010:  stk_wdata = left_r;
          default: stk_wdata = i_r - IW'(1);
        endcase
      end
      OP_EMIT: begin
        out_nxt = '{status: status_r, test_count: test_r, entry_id: rentry_r.id,
                    entry_is_max: rentry_r.is_max, entry_value: rentry_r.value,
                    endpoint_count: 9'(cnt_r)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
    if (stk_we) stk[stk_waddr] <= stk_wdata;
    if (stk_re) srdata_r <= stk[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;     i_r <= i_nxt;           j_r <= j_nxt;
    left_r <= left_nxt;   right_r <= right_nxt;   p1_r <= p1_nxt;
    found_r <= found_nxt; ir_r <= ir_nxt;         bigleft_r <= bigleft_nxt;
    moves_r <= moves_nxt; limit_r <= limit_nxt;   t_r <= t_nxt;
    piv_r <= piv_nxt;     a_r <= a_nxt;           rentry_r <= rentry_nxt;
    sp_r <= sp_nxt;       pushk_r <= pushk_nxt;   status_r <= status_nxt;
    open_r <= open_nxt;   sum_r <= sum_nxt;       test_r <= test_nxt;
    out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// ===== rtl/spe_checker.sv =====
`timescale 1ns / 1ps
`include "sweep_prune_endpoint_axis_top_defines.svh"
module spe_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input spe_pkg::out_t out_data
);
  import spe_pkg::*;

  `SPE_CHECK(a_result_held, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `SPE_CHECK(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second request taken while busy")
  `SPE_CHECK(a_status_code, out_valid |-> out_data.status != 2'd3, "bad status code")
  `SPE_CHECK(a_count_bound, out_valid |-> out_data.endpoint_count <= 9'd256, "count beyond store")
  `SPE_CHECK_RST(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind sweep_prune_endpoint_axis_top spe_checker u_spe_checker (.*);
